### rtl/core/gwa_pkg.sv
// ----------------------------------------------------------------------------
// gwa_pkg
// shared types and constants of the grain weighted averager
// ----------------------------------------------------------------------------
package gwa_pkg;

  // default limits
  localparam int unsigned DefMaxCellsPerGrain = 256;
  localparam int unsigned DefMaxGrains        = 4096;

  // fixed field widths
  localparam int unsigned StatesW   = 32;
  localparam int unsigned EnergyW   = 24;
  localparam int unsigned SumW      = 40;
  localparam int unsigned ProdW     = StatesW + EnergyW;
  localparam int unsigned AccW      = 64;
  localparam int unsigned SlotW     = 12;
  localparam int unsigned MadeW     = 13;
  localparam int unsigned CpgW      = 9;
  localparam int unsigned OffW      = 8;
  localparam int unsigned GcntW     = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned DivCntW   = 6;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELLS_PER_GRAIN = 2'd0,
    CFG_CELL_OFFSET     = 2'd1,
    CFG_GRAIN_COUNT     = 2'd2
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take input transaction, form product
    logic acc;       // accumulate and close grain if at end
    logic div_step;  // one quotient bit
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic grain_end;
    logic last_grain;
    logic nonzero;
    logic div_done;
  } sts_t;

endpackage

### rtl/core/grain_weighted_averager.sv
// ----------------------------------------------------------------------------
// grain_weighted_averager
// groups energy cells into grains and yields state sum and weighted mean
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i, in_ready_o, cell_states_i, cell_energy_i
// out     | output    | out_valid_o, out_ready_i, grain_* , done_res_o, ...
// cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// a cell that does not close a grain passes capture and accumulate
// a grain close with results passes capture, accumulate, 64 serial divider
// steps and result, plus the output wait; an empty closing grain with done
// passes capture, accumulate and result, plus the wait
// input is held off while a result waits for out_ready_i
// reset clears pass state and sets width 1, offset 0, request 1
// ----------------------------------------------------------------------------
module grain_weighted_averager #(
  parameter int unsigned MAX_CELLS_PER_GRAIN = gwa_pkg::DefMaxCellsPerGrain,
  parameter int unsigned MAX_GRAINS          = gwa_pkg::DefMaxGrains
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gwa_pkg::StatesW-1:0]   cell_states_i,
  input  logic [gwa_pkg::EnergyW-1:0]   cell_energy_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          grain_valid_o,
  output logic [gwa_pkg::SlotW-1:0]     grain_slot_o,
  output logic [gwa_pkg::SumW-1:0]      grain_states_o,
  output logic [gwa_pkg::EnergyW-1:0]   grain_energy_o,
  output logic                          done_res_o,
  output logic [gwa_pkg::MadeW-1:0]     grains_made_o,
  output logic                          short_of_request_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gwa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gwa_pkg::CfgDataW-1:0]  cfg_data_i
);

  gwa_pkg::cmd_t cmd;
  gwa_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  gwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath
  gwa_dp #(
    .MAX_CELLS_PER_GRAIN (MAX_CELLS_PER_GRAIN),
    .MAX_GRAINS          (MAX_GRAINS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cell_states_i      (cell_states_i),
    .cell_energy_i      (cell_energy_i),
    .grain_valid_o      (grain_valid_o),
    .grain_slot_o       (grain_slot_o),
    .grain_states_o     (grain_states_o),
    .grain_energy_o     (grain_energy_o),
    .done_res_o         (done_res_o),
    .grains_made_o      (grains_made_o),
    .short_of_request_o (short_of_request_o)
  );

endmodule

### rtl/core/gwa_dp.sv
// ----------------------------------------------------------------------------
// gwa_dp
// accumulators, grain counters, config registers and serial divider
// ----------------------------------------------------------------------------
module gwa_dp #(
  parameter int unsigned MAX_CELLS_PER_GRAIN = gwa_pkg::DefMaxCellsPerGrain,
  parameter int unsigned MAX_GRAINS          = gwa_pkg::DefMaxGrains
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gwa_pkg::cmd_t                 cmd_i,
  output gwa_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [gwa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gwa_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [gwa_pkg::StatesW-1:0]   cell_states_i,
  input  logic [gwa_pkg::EnergyW-1:0]   cell_energy_i,
  output logic                          grain_valid_o,
  output logic [gwa_pkg::SlotW-1:0]     grain_slot_o,
  output logic [gwa_pkg::SumW-1:0]      grain_states_o,
  output logic [gwa_pkg::EnergyW-1:0]   grain_energy_o,
  output logic                          done_res_o,
  output logic [gwa_pkg::MadeW-1:0]     grains_made_o,
  output logic                          short_of_request_o
);

  localparam int unsigned CpwRaw = $clog2(MAX_CELLS_PER_GRAIN + 1);
  localparam int unsigned WW     = (CpwRaw > gwa_pkg::CpgW) ? CpwRaw : gwa_pkg::CpgW;
  localparam int unsigned CPW    = (MAX_CELLS_PER_GRAIN > 1) ? $clog2(MAX_CELLS_PER_GRAIN) : 1;
  localparam int unsigned GwRaw  = $clog2(MAX_GRAINS + 1);
  localparam int unsigned GW     = (GwRaw > gwa_pkg::MadeW) ? GwRaw : gwa_pkg::MadeW;
  localparam int unsigned GPW    = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
  localparam logic [WW-1:0] MaxW = WW'(MAX_CELLS_PER_GRAIN);
  localparam logic [GW-1:0] MaxG = GW'(MAX_GRAINS);

  // configuration registers
  logic [gwa_pkg::CpgW-1:0]  cpg_q;
  logic [gwa_pkg::OffW-1:0]  off_q;
  logic [gwa_pkg::GcntW-1:0] gcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpg_q  <= gwa_pkg::CpgW'(1);
      off_q  <= '0;
      gcnt_q <= gwa_pkg::GcntW'(1);
    end else if (cfg_we_i) begin
      unique case (gwa_pkg::cfg_idx_e'(cfg_index_i))
        gwa_pkg::CFG_CELLS_PER_GRAIN: cpg_q  <= cfg_data_i[gwa_pkg::CpgW-1:0];
        gwa_pkg::CFG_CELL_OFFSET:     off_q  <= cfg_data_i[gwa_pkg::OffW-1:0];
        gwa_pkg::CFG_GRAIN_COUNT:     gcnt_q <= cfg_data_i[gwa_pkg::GcntW-1:0];
        default: ;
      endcase
    end
  end

  // clamped width and request
  logic [WW-1:0] width, off_ext, range, cpos_inc;
  logic [GW-1:0] req, gpos_inc, made_ext;

  always_comb begin
    width = WW'(cpg_q);
    if (width == '0) width = WW'(1);
    if (width > MaxW) width = MaxW;
    req = GW'(gcnt_q);
    if (req == '0) req = GW'(1);
    if (req > MaxG) req = MaxG;
  end

  // pass state
  logic [GPW-1:0]            gpos_q;
  logic [CPW-1:0]            cpos_q;
  logic [gwa_pkg::SumW-1:0]  ssum_q, ssum_d;
  logic [gwa_pkg::AccW-1:0]  esum_q, esum_d;
  logic [gwa_pkg::MadeW-1:0] prod_cnt_q, prod_cnt_inc;
  logic [gwa_pkg::StatesW-1:0] st_q;
  logic [gwa_pkg::ProdW-1:0]   mul_q;

  // grain range and end tests
  always_comb begin
    off_ext  = WW'(off_q);
    if (gpos_q == '0) range = (off_ext < width) ? (width - off_ext) : WW'(1);
    else              range = width;
    cpos_inc = WW'(cpos_q) + WW'(1);
    gpos_inc = GW'(gpos_q) + GW'(1);
    ssum_d   = ssum_q + gwa_pkg::SumW'(st_q);
    esum_d   = esum_q + gwa_pkg::AccW'(mul_q);
    prod_cnt_inc = prod_cnt_q + gwa_pkg::MadeW'(1);
  end

  assign sts_o.grain_end  = cpos_inc >= range;
  assign sts_o.last_grain = gpos_inc >= req;
  assign sts_o.nonzero    = ssum_d != '0;

  // produced count after this grain
  logic [gwa_pkg::MadeW-1:0] made_now;
  assign made_now = sts_o.nonzero ? prod_cnt_inc : prod_cnt_q;
  assign made_ext = GW'(made_now);

  // product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      st_q  <= cell_states_i;
      mul_q <= gwa_pkg::ProdW'(cell_states_i) * gwa_pkg::ProdW'(cell_energy_i);
    end
  end

  // accumulators and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpos_q     <= '0;
      cpos_q     <= '0;
      ssum_q     <= '0;
      esum_q     <= '0;
      prod_cnt_q <= '0;
    end else if (cmd_i.acc) begin
      if (!sts_o.grain_end) begin
        cpos_q <= cpos_q + CPW'(1);
        ssum_q <= ssum_d;
        esum_q <= esum_d;
      end else begin
        cpos_q <= '0;
        ssum_q <= '0;
        esum_q <= '0;
        if (sts_o.last_grain) begin
          gpos_q     <= '0;
          prod_cnt_q <= '0;
        end else begin
          gpos_q     <= gpos_q + GPW'(1);
          prod_cnt_q <= made_now;
        end
      end
    end
  end

  // result payload latched at grain close
  logic                       gv_q, done_q, short_q;
  logic [gwa_pkg::SlotW-1:0]  slot_q;
  logic [gwa_pkg::SumW-1:0]   gst_q;
  logic [gwa_pkg::MadeW-1:0]  made_q;

  // restoring divider, one quotient bit per step
  logic [gwa_pkg::AccW-1:0]   quo_q;
  logic [gwa_pkg::SumW:0]     rem_q, rem_sh;
  logic [gwa_pkg::SumW-1:0]   dvs_q;
  logic [gwa_pkg::DivCntW-1:0] dcnt_q;
  logic                       fits;

  assign rem_sh = {rem_q[gwa_pkg::SumW-1:0], quo_q[gwa_pkg::AccW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign sts_o.div_done = dcnt_q == '1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && sts_o.grain_end) begin
      gv_q    <= sts_o.nonzero;
      slot_q  <= sts_o.nonzero ? prod_cnt_q[gwa_pkg::SlotW-1:0] : '0;
      gst_q   <= sts_o.nonzero ? ssum_d : '0;
      done_q  <= sts_o.last_grain;
      made_q  <= sts_o.last_grain ? made_now : '0;
      short_q <= sts_o.last_grain && (made_ext < req);
      quo_q   <= sts_o.nonzero ? esum_d : '0;
      rem_q   <= '0;
      dvs_q   <= ssum_d;
      dcnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[gwa_pkg::AccW-2:0], fits};
      rem_q  <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dcnt_q <= dcnt_q + gwa_pkg::DivCntW'(1);
    end
  end

  // outputs, mean saturated to the energy range
  assign grain_valid_o      = gv_q;
  assign grain_slot_o       = slot_q;
  assign grain_states_o     = gst_q;
  assign grain_energy_o     = (|quo_q[gwa_pkg::AccW-1:gwa_pkg::EnergyW]) ? '1
                              : quo_q[gwa_pkg::EnergyW-1:0];
  assign done_res_o         = done_q;
  assign grains_made_o      = made_q;
  assign short_of_request_o = short_q;

endmodule

### rtl/core/gwa_ctrl.sv
// ----------------------------------------------------------------------------
// gwa_ctrl
// sequencer for capture, accumulate, divide and result hand-off
// ----------------------------------------------------------------------------
module gwa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gwa_pkg::cmd_t cmd_o,
  input  gwa_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = state_q == S_OUT;
  assign cmd_o.capture    = in_valid_i && in_ready_o;
  assign cmd_o.acc        = state_q == S_ACC;
  assign cmd_o.div_step   = state_q == S_DIV;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_ACC;
        S_ACC: begin
          if (!sts_i.grain_end)   state_q <= S_IDLE;
          else if (sts_i.nonzero) state_q <= S_DIV;
          else if (sts_i.last_grain) state_q <= S_OUT;
          else                    state_q <= S_IDLE;
        end
        S_DIV: if (sts_i.div_done) state_q <= S_OUT;
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and result both open");
  a_close_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.acc && sts_i.grain_end && sts_i.nonzero) |=> cmd_o.div_step)
    else $error("nonempty grain did not start division");
  a_open_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.acc && !sts_i.grain_end) |=> in_ready_o)
    else $error("mid-grain cell did not return to idle");

endmodule
